@@ hw/rtl/lru_block_cache_directory_assert.svh @@
// assertion macros shared by the directory rtl
`ifndef LRU_BLOCK_CACHE_DIRECTORY_ASSERT_SVH
`define LRU_BLOCK_CACHE_DIRECTORY_ASSERT_SVH

// clocked assertion, disabled while reset is low
`define LBCD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("lbcd assertion failed");

// clocked assertion, checked during reset too
`define LBCD_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("lbcd assertion failed");

`endif

@@ hw/rtl/lbcd_pkg.sv @@
// ----------------------------------------------------------------------------
// lbcd_pkg
// types, constants and codes of the lru block cache directory
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lbcd_pkg;

  localparam int unsigned ENTRIES = 64;
  localparam int unsigned IDX_W   = $clog2(ENTRIES);
  localparam int unsigned RANK_W  = IDX_W;
  localparam int unsigned CNT_W   = $clog2(ENTRIES + 1);
  localparam int unsigned CAP_W   = 7;
  localparam int unsigned FILL_W  = 7;
  localparam int unsigned CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  // operation codes
  localparam logic [2:0] FUNC_LOOKUP = 3'd0;
  localparam logic [2:0] FUNC_PROBE  = 3'd1;
  localparam logic [2:0] FUNC_TOUCH  = 3'd2;
  localparam logic [2:0] FUNC_REMOVE = 3'd3;
  localparam logic [2:0] FUNC_INSERT = 3'd4;

  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_ABSENT = 1'b1;

  typedef struct packed {
    logic [63:0] block;
    logic [7:0]  server;
    logic [7:0]  volume;
  } key_t;

  typedef struct packed {
    key_t              key;
    logic [31:0]       wcount;
    logic [RANK_W-1:0] rank;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [2:0]  func;
    logic [63:0] block;
    logic [7:0]  server;
    logic [7:0]  volume;
    logic        is_write;
  } in_t;

  typedef struct packed {
    logic              hit;
    logic              status;
    logic              evicted;
    logic [63:0]       evicted_block;
    logic [7:0]        evicted_server;
    logic [7:0]        evicted_volume;
    logic [31:0]       wr_hit_cnt;
    logic [FILL_W-1:0] fill;
  } out_t;

endpackage

`default_nettype wire

@@ hw/rtl/lru_block_cache_directory.sv @@
// ----------------------------------------------------------------------------
// lru_block_cache_directory
// fully associative lru directory of cached blocks with a sequenced scan
// ----------------------------------------------------------------------------
// One transaction at a time. After acceptance the sequencer sweeps the entry
// ram once to find the most recent matching key, the least recent entry and
// the first free slot, decides, and for operations that change recency
// sweeps the ram again with a read-modify-write of every rank, then hands the
// result to the output register. Probe, misses of lookup, touch and remove,
// and unknown codes skip the second sweep; the result waits in the done state
// until the output register is free. The single port pair of the entry ram
// sets both sweeps. in_stall_o is high whenever the sequencer is not idle.
// Capacity is written on the cfg port, which is always ready; values below 2
// act as 2 and above ENTRIES act as ENTRIES. Tags, write counts and ranks
// live in the ram with no clearing pass; of the directory state only the
// per-entry valid flops and the fill count are reset.
`timescale 1ns / 1ps
`default_nettype none

module lru_block_cache_directory (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire lbcd_pkg::in_t      in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output lbcd_pkg::out_t          out_data_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [lbcd_pkg::CAP_W-1:0] cfg_data_i
);

`include "lru_block_cache_directory_assert.svh"

  localparam int unsigned IDX_W  = lbcd_pkg::IDX_W;
  localparam int unsigned RANK_W = lbcd_pkg::RANK_W;
  localparam int unsigned CNT_W  = lbcd_pkg::CNT_W;
  localparam int unsigned CMP_W  = lbcd_pkg::CMP_W;

  // sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_DECIDE = 3'd2;
  localparam logic [2:0] ST_UPD    = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  logic [2:0] state_q, state_d;

  // configuration
  logic [lbcd_pkg::CAP_W-1:0] cap_q;

  // request and sweep control
  lbcd_pkg::in_t    req_q, req_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             pend_q, pend_d;
  logic [IDX_W-1:0] pidx_q, pidx_d;

  // directory state in flops
  logic [lbcd_pkg::ENTRIES-1:0] valid_q, valid_d;
  logic [CNT_W-1:0]             occ_q, occ_d;

  // scan findings
  logic              best_f_q, best_f_d;
  logic [IDX_W-1:0]  best_i_q, best_i_d;
  logic [RANK_W-1:0] best_r_q, best_r_d;
  logic [31:0]       best_w_q, best_w_d;
  logic              max_f_q, max_f_d;
  logic [IDX_W-1:0]  max_i_q, max_i_d;
  logic [RANK_W-1:0] max_r_q, max_r_d;
  lbcd_pkg::key_t    max_k_q, max_k_d;
  logic              free_f_q, free_f_d;
  logic [IDX_W-1:0]  free_i_q, free_i_d;

  // update plan
  logic              remove_q, remove_d;   // remove ages down, else promote
  logic [CNT_W-1:0]  thr_q, thr_d;
  logic              slot_en_q, slot_en_d;
  logic              slot_ins_q, slot_ins_d;
  logic [IDX_W-1:0]  slot_q, slot_d;
  logic [31:0]       new_w_q, new_w_d;

  // result and output register
  lbcd_pkg::out_t res_q, res_d;
  lbcd_pkg::out_t out_q;
  logic           out_valid_q;

  // ram ports
  logic                  ram_we;
  logic [IDX_W-1:0]      ram_raddr;
  lbcd_pkg::entry_t      ram_rdata;
  lbcd_pkg::entry_t      ram_wdata;
  logic [lbcd_pkg::ENTRY_W-1:0] ram_rdata_raw;

  lbcd_ram #(
    .WIDTH (lbcd_pkg::ENTRY_W),
    .DEPTH (lbcd_pkg::ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (pidx_q),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata_raw)
  );

  assign ram_rdata = lbcd_pkg::entry_t'(ram_rdata_raw);
  assign ram_raddr = cnt_q[IDX_W-1:0];

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // search key of the held request
  lbcd_pkg::key_t req_key;
  assign req_key = '{block: req_q.block, server: req_q.server, volume: req_q.volume};

  // effective capacity, clamped to the legal range
  logic [CMP_W-1:0] cap_ext, eff_cap, occ_ext;
  always_comb begin
    cap_ext = CMP_W'(cap_q);
    occ_ext = CMP_W'(occ_q);
    if (cap_ext < CMP_W'(2)) begin
      eff_cap = CMP_W'(2);
    end else if (cap_ext > CMP_W'(lbcd_pkg::ENTRIES)) begin
      eff_cap = CMP_W'(lbcd_pkg::ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  logic             issue;
  logic             ent_v;
  logic             key_eq;
  logic [31:0]      sat_w;
  logic [CMP_W-1:0] fill_ext;

  always_comb begin
    state_d    = state_q;
    req_d      = req_q;
    cnt_d      = cnt_q;
    pend_d     = 1'b0;
    pidx_d     = pidx_q;
    valid_d    = valid_q;
    occ_d      = occ_q;
    best_f_d   = best_f_q;
    best_i_d   = best_i_q;
    best_r_d   = best_r_q;
    best_w_d   = best_w_q;
    max_f_d    = max_f_q;
    max_i_d    = max_i_q;
    max_r_d    = max_r_q;
    max_k_d    = max_k_q;
    free_f_d   = free_f_q;
    free_i_d   = free_i_q;
    remove_d   = remove_q;
    thr_d      = thr_q;
    slot_en_d  = slot_en_q;
    slot_ins_d = slot_ins_q;
    slot_d     = slot_q;
    new_w_d    = new_w_q;
    res_d      = res_q;
    ram_we     = 1'b0;
    ram_wdata  = ram_rdata;
    issue      = (cnt_q != CNT_W'(lbcd_pkg::ENTRIES));
    ent_v      = valid_q[pidx_q];
    key_eq     = (ram_rdata.key == req_key);
    sat_w      = (best_w_q == 32'hFFFF_FFFF) ? best_w_q : best_w_q + 32'd1;
    fill_ext   = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d    = in_data_i;
          cnt_d    = '0;
          best_f_d = 1'b0;
          max_f_d  = 1'b0;
          free_f_d = 1'b0;
          state_d  = ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (issue) begin
          cnt_d  = cnt_q + CNT_W'(1);
          pend_d = 1'b1;
          pidx_d = ram_raddr;
        end
        if (pend_q) begin
          // most recent matching entry
          if (ent_v && key_eq && (!best_f_q || ram_rdata.rank < best_r_q)) begin
            best_f_d = 1'b1;
            best_i_d = pidx_q;
            best_r_d = ram_rdata.rank;
            best_w_d = ram_rdata.wcount;
          end
          // least recent entry
          if (ent_v && (!max_f_q || ram_rdata.rank > max_r_q)) begin
            max_f_d = 1'b1;
            max_i_d = pidx_q;
            max_r_d = ram_rdata.rank;
            max_k_d = ram_rdata.key;
          end
          // lowest free slot
          if (!ent_v && !free_f_q) begin
            free_f_d = 1'b1;
            free_i_d = pidx_q;
          end
        end
        if (!issue && !pend_q) begin
          state_d = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        res_d      = '0;
        remove_d   = 1'b0;
        slot_en_d  = 1'b0;
        slot_ins_d = 1'b0;
        thr_d      = CNT_W'(best_r_q);
        slot_d     = best_i_q;
        new_w_d    = best_w_q;
        state_d    = ST_DONE;
        res_d.hit  = best_f_q && (req_q.func <= lbcd_pkg::FUNC_INSERT);
        case (req_q.func)
          lbcd_pkg::FUNC_LOOKUP: begin
            if (best_f_q) begin
              new_w_d          = req_q.is_write ? sat_w : best_w_q;
              res_d.wr_hit_cnt = req_q.is_write ? sat_w : best_w_q;
              slot_en_d        = 1'b1;
              state_d          = ST_UPD;
            end
          end
          lbcd_pkg::FUNC_PROBE: begin
            if (best_f_q) begin
              res_d.wr_hit_cnt = best_w_q;
            end
          end
          lbcd_pkg::FUNC_TOUCH: begin
            if (best_f_q) begin
              res_d.wr_hit_cnt = best_w_q;
              slot_en_d        = 1'b1;
              state_d          = ST_UPD;
            end else begin
              res_d.status = lbcd_pkg::STATUS_ABSENT;
            end
          end
          lbcd_pkg::FUNC_REMOVE: begin
            if (best_f_q) begin
              res_d.wr_hit_cnt  = best_w_q;
              remove_d          = 1'b1;
              valid_d[best_i_q] = 1'b0;
              occ_d             = occ_q - CNT_W'(1);
              state_d           = ST_UPD;
            end else begin
              res_d.status = lbcd_pkg::STATUS_ABSENT;
            end
          end
          lbcd_pkg::FUNC_INSERT: begin
            slot_en_d  = 1'b1;
            slot_ins_d = 1'b1;
            new_w_d    = '0;
            state_d    = ST_UPD;
            if (occ_ext >= eff_cap) begin
              // evict the least recent entry and reuse its slot
              res_d.evicted        = 1'b1;
              res_d.evicted_block  = max_k_q.block;
              res_d.evicted_server = max_k_q.server;
              res_d.evicted_volume = max_k_q.volume;
              slot_d               = max_i_q;
              thr_d                = CNT_W'(max_r_q);
            end else begin
              // new entry, every valid entry ages by one
              slot_d            = free_i_q;
              thr_d             = CNT_W'(lbcd_pkg::ENTRIES);
              valid_d[free_i_q] = 1'b1;
              occ_d             = occ_q + CNT_W'(1);
            end
          end
          default: begin
          end
        endcase
        fill_ext   = CMP_W'(occ_d);
        res_d.fill = fill_ext[lbcd_pkg::FILL_W-1:0];
        cnt_d      = '0;
      end

      ST_UPD: begin
        if (issue) begin
          cnt_d  = cnt_q + CNT_W'(1);
          pend_d = 1'b1;
          pidx_d = ram_raddr;
        end
        if (pend_q) begin
          ram_we = 1'b1;
          if (slot_en_q && pidx_q == slot_q) begin
            ram_wdata.rank   = '0;
            ram_wdata.wcount = new_w_q;
            if (slot_ins_q) begin
              ram_wdata.key = req_key;
            end
          end else if (ent_v) begin
            if (remove_q) begin
              if (CNT_W'(ram_rdata.rank) > thr_q) begin
                ram_wdata.rank = ram_rdata.rank - RANK_W'(1);
              end
            end else if (CNT_W'(ram_rdata.rank) < thr_q) begin
              ram_wdata.rank = ram_rdata.rank + RANK_W'(1);
            end
          end
        end
        if (!issue && !pend_q) begin
          state_d = ST_DONE;
        end
      end

      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cap_q       <= lbcd_pkg::CAP_W'(64);
      valid_q     <= '0;
      occ_q       <= '0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      occ_q   <= occ_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
      if (state_q == ST_DONE && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    pidx_q     <= pidx_d;
    best_f_q   <= best_f_d;
    best_i_q   <= best_i_d;
    best_r_q   <= best_r_d;
    best_w_q   <= best_w_d;
    max_f_q    <= max_f_d;
    max_i_q    <= max_i_d;
    max_r_q    <= max_r_d;
    max_k_q    <= max_k_d;
    free_f_q   <= free_f_d;
    free_i_q   <= free_i_d;
    remove_q   <= remove_d;
    thr_q      <= thr_d;
    slot_en_q  <= slot_en_d;
    slot_ins_q <= slot_ins_d;
    slot_q     <= slot_d;
    new_w_q    <= new_w_d;
    res_q      <= res_d;
    if (state_q == ST_DONE && (!out_valid_q || !out_stall_i)) begin
      out_q <= res_q;
    end
  end

  // fill count tracks the valid flops
  `LBCD_ASSERT(a_fill_matches_valid, clk_i, rst_ni, $countones(valid_q) == occ_q)
  // fill never passes the entry count
  `LBCD_ASSERT(a_fill_bound, clk_i, rst_ni, occ_q <= CNT_W'(lbcd_pkg::ENTRIES))
  // ram is written only during the update sweep
  `LBCD_ASSERT_ALWAYS(a_we_in_update, clk_i, ram_we |-> (state_q == ST_UPD))
  // a new result appears only out of the done state
  `LBCD_ASSERT(a_out_from_done, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q == ST_DONE))

endmodule

`default_nettype wire

@@ hw/rtl/lbcd_ram.sv @@
// ----------------------------------------------------------------------------
// lbcd_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lbcd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire
